FILE: hw/rtl/hqm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hqm_pkg: shared constants and types of the two-queue Huffman merge
// Sizes of the leaf and node queues, id and weight widths, queue front types.
// ----------------------------------------------------------------------------
package hqm_pkg;

	localparam int unsigned MAX_LEAVES  = 64;
	localparam int unsigned WEIGHT_BITS = 24;

	// Node weight width and saturation value
	localparam int unsigned SUM_W = 30;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// Width used for compare and add of queue fronts
	localparam int unsigned CMP_W = (WEIGHT_BITS > SUM_W) ? WEIGHT_BITS : SUM_W;
	localparam int unsigned ADD_W = CMP_W + 1;

	// Node ids: leaves from zero, internal nodes from NODE_BASE
	localparam int unsigned ID_W = 7;
	localparam logic [ID_W-1:0] NODE_BASE = 7'd64;

	localparam int unsigned CNT_W     = $clog2(MAX_LEAVES + 1);
	localparam int unsigned LIDX_W    = $clog2(MAX_LEAVES);
	localparam int unsigned INT_DEPTH = MAX_LEAVES - 1;
	localparam int unsigned IIDX_W    = (INT_DEPTH > 1) ? $clog2(INT_DEPTH) : 1;

	// Both queue fronts as seen by the selector
	typedef struct packed {
		logic            leaf_ok;
		logic            int_ok;
		logic [CMP_W-1:0] leaf_w;
		logic [CMP_W-1:0] int_w;
		logic [ID_W-1:0]  leaf_id;
		logic [ID_W-1:0]  int_id;
	} front_t;

	// Selected front
	typedef struct packed {
		logic            take_leaf;
		logic [ID_W-1:0]  id;
		logic [CMP_W-1:0] weight;
	} pick_t;

endpackage

FILE: hw/rtl/hqm_leaf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hqm_leaf_if: leaf weight channel
// One beat carries one leaf weight and the end-of-set mark.
// ----------------------------------------------------------------------------
interface hqm_leaf_if;

	logic                            valid;
	logic                            ready;
	logic [hqm_pkg::WEIGHT_BITS-1:0] leaf_weight;
	logic                            last_leaf;

	modport source (output valid, output leaf_weight, output last_leaf, input ready);
	modport sink   (input valid, input leaf_weight, input last_leaf, output ready);

endinterface

FILE: hw/rtl/hqm_node_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hqm_node_if: internal node result channel
// One beat carries one new tree node with its children and flags.
// ----------------------------------------------------------------------------
interface hqm_node_if;

	logic                      valid;
	logic                      ready;
	logic [hqm_pkg::ID_W-1:0]  node_id;
	logic [hqm_pkg::ID_W-1:0]  left_id;
	logic [hqm_pkg::ID_W-1:0]  right_id;
	logic [hqm_pkg::SUM_W-1:0] node_weight;
	logic                      lone_leaf;
	logic                      leaves_dropped;
	logic                      is_root;

	modport source (output valid, output node_id, output left_id, output right_id,
		output node_weight, output lone_leaf, output leaves_dropped, output is_root,
		input ready);
	modport sink (input valid, input node_id, input left_id, input right_id,
		input node_weight, input lone_leaf, input leaves_dropped, input is_root,
		output ready);

endinterface

FILE: hw/rtl/hqm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hqm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hqm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/hqm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hqm_front: queue front selector
// Picks the lighter of the two queue fronts; a tie goes to the leaf queue.
// ----------------------------------------------------------------------------
module hqm_front (
	input  hqm_pkg::front_t front,
	output hqm_pkg::pick_t  pick
);

	logic take_leaf;

	assign take_leaf = front.leaf_ok && (!front.int_ok || (front.leaf_w <= front.int_w));

	always_comb begin
		pick.take_leaf = take_leaf;
		pick.id        = take_leaf ? front.leaf_id : front.int_id;
		pick.weight    = take_leaf ? front.leaf_w : front.int_w;
	end

endmodule

FILE: hw/rtl/huffman_two_queue_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_two_queue_merge: two-queue Huffman tree builder
// Loads sorted leaf weights into a leaf RAM, then merges them into a tree.
// ----------------------------------------------------------------------------
// Usage
//  - leaf: one beat per leaf weight, ascending; leaf ids follow beat order.
//    The beat with last_leaf set closes the set and starts the merge. Leaves
//    past MAX_LEAVES are thrown away and flag every result of that set.
//  - node: one beat per new internal node, in creation order; the beat with
//    is_root set is the last one of the set. A single-leaf set gives one beat
//    flagged lone_leaf, whose root is leaf 0.
//  - Loading accepts a leaf beat in each cycle with leaf.ready high. The merge
//    makes two picks per node, in ST_PICK1 and then ST_PICK2: each pick needs
//    the fresh queue front, which the leaf RAM and node RAM return in the
//    cycle after the pick that moves the head.
//  - leaf.ready is low while a merge runs, and while a result waits in the
//    output register with node.ready low.
//  - A stalled receiver holds the merge in its second pick; nothing is lost.
//  - Reset empties both queues; RAM contents are not cleared (entries are
//    only read after they were written in the same set).
// ----------------------------------------------------------------------------
module huffman_two_queue_merge (
	input logic       clk,
	input logic       arst_n,
	hqm_leaf_if.sink  leaf,
	hqm_node_if.source node
);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_PICK1 = 2'd1;
	localparam logic [1:0] ST_PICK2 = 2'd2;

	logic [1:0] state_q;

	// queue pointers
	logic [hqm_pkg::CNT_W-1:0]  cnt_q, lhead_q, lhead_d;
	logic [hqm_pkg::IIDX_W-1:0] ihead_q, ihead_d, itail_q;
	logic                       ovf_q, drop_q;

	// first pick of a node
	logic [hqm_pkg::ID_W-1:0]  first_id_q;
	logic [hqm_pkg::CMP_W-1:0] first_w_q;

	// forward of a node written while its entry is read
	logic                      fwd_sel_q;
	logic [hqm_pkg::CMP_W-1:0] fwd_w_q;

	// RAM ports
	logic [hqm_pkg::WEIGHT_BITS-1:0] leaf_rdata;
	logic [hqm_pkg::SUM_W-1:0]       int_rdata;
	logic                            leaf_we, int_we;

	// output register
	logic                      out_valid_q;
	logic [hqm_pkg::ID_W-1:0]  out_node_q, out_left_q, out_right_q;
	logic [hqm_pkg::SUM_W-1:0] out_w_q;
	logic                      out_lone_q, out_drop_q, out_root_q;

	logic                      out_free, leaf_beat, not_full, lone, advance, is_root_c;
	logic [hqm_pkg::ADD_W-1:0] sum;
	logic [hqm_pkg::SUM_W-1:0] sum_sat;
	hqm_pkg::front_t           front;
	hqm_pkg::pick_t            pick;

	assign out_free  = !out_valid_q || node.ready;
	assign leaf.ready = (state_q == ST_LOAD) && out_free;
	assign leaf_beat = leaf.valid && leaf.ready;
	assign not_full  = cnt_q != hqm_pkg::CNT_W'(hqm_pkg::MAX_LEAVES);
	assign lone      = leaf_beat && leaf.last_leaf && (cnt_q == '0);
	// first pick always moves on; second waits for room in the output register
	assign advance   = (state_q == ST_PICK1) || ((state_q == ST_PICK2) && out_free);

	// queue fronts
	always_comb begin
		front.leaf_ok = lhead_q < cnt_q;
		front.int_ok  = ihead_q < itail_q;
		front.leaf_w  = hqm_pkg::CMP_W'(leaf_rdata);
		front.int_w   = fwd_sel_q ? fwd_w_q : hqm_pkg::CMP_W'(int_rdata);
		front.leaf_id = hqm_pkg::ID_W'(lhead_q);
		front.int_id  = hqm_pkg::NODE_BASE + hqm_pkg::ID_W'(ihead_q);
	end

	hqm_front u_front (
		.front (front),
		.pick  (pick)
	);

	// heads after this cycle's pick; they also address the RAM reads
	always_comb begin
		lhead_d = lhead_q;
		ihead_d = ihead_q;
		if (advance) begin
			if (pick.take_leaf) begin
				lhead_d = lhead_q + 1'b1;
			end else begin
				ihead_d = ihead_q + 1'b1;
			end
		end
	end

	// node weight, saturating
	assign sum     = hqm_pkg::ADD_W'(first_w_q) + hqm_pkg::ADD_W'(pick.weight);
	assign sum_sat = (|sum[hqm_pkg::ADD_W-1:hqm_pkg::SUM_W]) ? hqm_pkg::SUM_MAX
		: sum[hqm_pkg::SUM_W-1:0];
	// a set of n leaves ends with node n-2
	assign is_root_c = (hqm_pkg::CNT_W'(itail_q) + hqm_pkg::CNT_W'(2)) == cnt_q;

	assign leaf_we = leaf_beat && not_full;
	assign int_we  = (state_q == ST_PICK2) && out_free;

	hqm_ram #(
		.WIDTH (hqm_pkg::WEIGHT_BITS),
		.DEPTH (hqm_pkg::MAX_LEAVES)
	) u_leaf_ram (
		.clk   (clk),
		.we    (leaf_we),
		.waddr (cnt_q[hqm_pkg::LIDX_W-1:0]),
		.wdata (leaf.leaf_weight),
		.raddr (lhead_d[hqm_pkg::LIDX_W-1:0]),
		.rdata (leaf_rdata)
	);

	hqm_ram #(
		.WIDTH (hqm_pkg::SUM_W),
		.DEPTH (hqm_pkg::INT_DEPTH)
	) u_int_ram (
		.clk   (clk),
		.we    (int_we),
		.waddr (itail_q),
		.wdata (sum_sat),
		.raddr (ihead_d),
		.rdata (int_rdata)
	);

	// sequencer and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			lhead_q   <= '0;
			ihead_q   <= '0;
			itail_q   <= '0;
			ovf_q     <= 1'b0;
			drop_q    <= 1'b0;
			fwd_sel_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					fwd_sel_q <= 1'b0;
					if (leaf_beat) begin
						if (lone) begin
							ovf_q <= 1'b0;
						end else begin
							if (not_full) begin
								cnt_q <= cnt_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
							if (leaf.last_leaf) begin
								drop_q  <= ovf_q || !not_full;
								state_q <= ST_PICK1;
							end
						end
					end
				end
				ST_PICK1: begin
					lhead_q   <= lhead_d;
					ihead_q   <= ihead_d;
					fwd_sel_q <= 1'b0;
					state_q   <= ST_PICK2;
				end
				ST_PICK2: begin
					if (out_free) begin
						if (is_root_c) begin
							state_q <= ST_LOAD;
							cnt_q   <= '0;
							lhead_q <= '0;
							ihead_q <= '0;
							itail_q <= '0;
							ovf_q   <= 1'b0;
						end else begin
							state_q <= ST_PICK1;
							lhead_q <= lhead_d;
							ihead_q <= ihead_d;
							itail_q <= itail_q + 1'b1;
						end
						// next read hits the entry written now
						fwd_sel_q <= ihead_d == itail_q;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// first pick and forwarded weight
	always_ff @(posedge clk) begin
		if (state_q == ST_PICK1) begin
			first_id_q <= pick.id;
			first_w_q  <= pick.weight;
		end
		if (int_we) begin
			fwd_w_q <= hqm_pkg::CMP_W'(sum_sat);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (lone || int_we) begin
			out_valid_q <= 1'b1;
		end else if (node.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (lone) begin
			out_node_q  <= '0;
			out_left_q  <= '0;
			out_right_q <= '0;
			out_w_q     <= hqm_pkg::SUM_W'(leaf.leaf_weight);
			out_lone_q  <= 1'b1;
			out_drop_q  <= ovf_q;
			out_root_q  <= 1'b1;
		end else if (int_we) begin
			out_node_q  <= hqm_pkg::NODE_BASE + hqm_pkg::ID_W'(itail_q);
			out_left_q  <= first_id_q;
			out_right_q <= pick.id;
			out_w_q     <= sum_sat;
			out_lone_q  <= 1'b0;
			out_drop_q  <= drop_q;
			out_root_q  <= is_root_c;
		end
	end

	assign node.valid          = out_valid_q;
	assign node.node_id        = out_node_q;
	assign node.left_id        = out_left_q;
	assign node.right_id       = out_right_q;
	assign node.node_weight    = out_w_q;
	assign node.lone_leaf      = out_lone_q;
	assign node.leaves_dropped = out_drop_q;
	assign node.is_root        = out_root_q;

	// the second pick always finds a non-empty queue
	a_pick2_has_front: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PICK2) |-> (front.leaf_ok || front.int_ok))
		else $error("second pick with both queues empty");

	// the root node closes the set
	a_root_ends_set: assert property (@(posedge clk) disable iff (!arst_n)
		(int_we && is_root_c) |=> (state_q == ST_LOAD) && (cnt_q == '0))
		else $error("set not cleared after root");

	// a stalled second pick keeps both heads
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_PICK2) && !out_free) |=> $stable(lhead_q) && $stable(ihead_q))
		else $error("queue head moved during output stall");

endmodule
